[sv/rpf_pkg.sv]
`timescale 1ns / 1ps

package rpf_pkg;

    // Field widths of the palette entry and the RGB555 color.
    localparam int unsigned INDEX_W   = 8;
    localparam int unsigned COLOR_W   = 15;
    localparam int unsigned CHAN_W    = 5;
    localparam int unsigned LEVEL_W   = 7;
    localparam int unsigned HALF_W    = 6;
    localparam int unsigned MASK_W    = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Unity brightness, blend span and the reset blend color.
    localparam logic [LEVEL_W-1:0] UNITY_LEVEL  = 7'd64;
    localparam logic [HALF_W-1:0]  BLEND_SPAN   = 6'd32;
    localparam logic [COLOR_W-1:0] RESET_BLEND  = 15'h1084;
    localparam logic [MASK_W-1:0]  RESET_MASK   = 16'h0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHT_FIRST  = 2'd0,
        CFG_BRIGHT_SECOND = 2'd1,
        CFG_FADE_MASK     = 2'd2,
        CFG_BLEND_COLOR   = 2'd3
    } t_cfg_idx;

    // One palette entry on the input channel.
    typedef struct packed {
        logic [INDEX_W-1:0] entry_index;
        logic [COLOR_W-1:0] source_color;
    } t_in_item;

    // One faded entry on the output channel.
    typedef struct packed {
        logic [INDEX_W-1:0] entry_out;
        logic [COLOR_W-1:0] faded_color;
        logic [LEVEL_W-1:0] effective_level;
    } t_out_item;

endpackage

[sv/rgb555_palette_row_fade.sv]
`timescale 1ns / 1ps

// Palette row fade: brightness fade and color blend of RGB555 palette entries.
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one palette entry,
// index and color, per handshake. Output channel (o_out_valid / i_out_ready /
// o_out_item) returns the entry index, the faded color and the current level.
// The configuration port writes one register per cycle when i_cfg_we is high:
// two brightness factors (the low seven bits, with values above 64 stored as 64),
// the row mask and the blend color. The user must write configuration only
// while no item is in flight; the block itself does not enforce it.
// An accepted item goes through an input register, then a result register.
// Throughput: one item per cycle while the receiver is ready, held by the
// two-stage valid/ready pipeline. The factor product is registered from the
// configuration registers, so the per-item path holds only the six 5x6-bit
// channel products and their sums. When the receiver stalls, the result
// register holds and the input register still takes one more item; further
// items wait until the result is taken. Reset empties both stages, sets both
// factors to unity, clears the row mask and sets the blend color to 0x1084.

module rgb555_palette_row_fade (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rpf_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rpf_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_we,
    input  logic [rpf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rpf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rpf_pkg::*;

    logic [LEVEL_W-1:0]   r_bright_first;
    logic [LEVEL_W-1:0]   r_bright_second;
    logic [MASK_W-1:0]    r_fade_mask;
    logic [COLOR_W-1:0]   r_blend_color;
    logic [LEVEL_W-1:0]   r_level;
    logic [HALF_W-1:0]    r_half;
    logic [2*LEVEL_W-1:0] prod;
    logic [LEVEL_W-1:0]   cfg_factor;

    logic                 r_s1_vld;
    t_in_item             r_s1_item;
    logic                 r_out_vld;
    t_out_item            r_out_item;
    logic                 s1_advance;
    logic                 in_take;
    logic                 fade_en;
    logic [COLOR_W-1:0]   mix_color;

    // Factor writes keep the low seven bits and clamp to unity.
    assign cfg_factor = (i_cfg_data[LEVEL_W-1:0] > UNITY_LEVEL) ?
                        UNITY_LEVEL : i_cfg_data[LEVEL_W-1:0];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright_first  <= UNITY_LEVEL;
            r_bright_second <= UNITY_LEVEL;
            r_fade_mask     <= RESET_MASK;
            r_blend_color   <= RESET_BLEND;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BRIGHT_FIRST:  r_bright_first  <= cfg_factor;
                CFG_BRIGHT_SECOND: r_bright_second <= cfg_factor;
                CFG_FADE_MASK:     r_fade_mask     <= i_cfg_data[MASK_W-1:0];
                CFG_BLEND_COLOR:   r_blend_color   <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Level and blend weight are registered from the factor product, in the cycle after a factor write.
    assign prod = {{LEVEL_W{1'b0}}, r_bright_first} * {{LEVEL_W{1'b0}}, r_bright_second};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= UNITY_LEVEL;
            r_half  <= BLEND_SPAN;
        end else begin
            r_level <= prod[6 +: LEVEL_W];
            r_half  <= prod[7 +: HALF_W];
        end
    end

    // Pipeline handshake: each stage moves when the stage after it frees up.
    assign s1_advance = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_vld <= 1'b1;
            end else if (s1_advance) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item <= i_in_item;
        end
    end

    // A row is faded when its mask bit is set and the level is below unity.
    assign fade_en = (r_level != UNITY_LEVEL) &&
                     r_fade_mask[r_s1_item.entry_index[INDEX_W-1 -: 4]];

    rpf_mix u_mix (
        .i_source  (r_s1_item.source_color),
        .i_blend   (r_blend_color),
        .i_half    (r_half),
        .i_fade_en (fade_en),
        .o_color   (mix_color)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_item.entry_out       <= r_s1_item.entry_index;
            r_out_item.faded_color     <= mix_color;
            r_out_item.effective_level <= r_level;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    // Stored factors never exceed unity, whatever was written.
    a_factor_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bright_first <= UNITY_LEVEL) && (r_bright_second <= UNITY_LEVEL))
        else $error("brightness factor above unity");

    // The reported level matches the current configuration.
    a_level_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.effective_level == r_level))
        else $error("stale effective level on output");

    // At level zero a faded row gives exactly the blend color.
    a_level_zero_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.effective_level == '0) &&
         r_fade_mask[o_out_item.entry_out[INDEX_W-1 -: 4]])
        |-> (o_out_item.faded_color == r_blend_color))
        else $error("level zero did not yield blend color");

    // A held input item moves on whenever the result stage is empty.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !r_out_vld) |=> r_out_vld)
        else $error("pipeline failed to advance into empty result stage");

endmodule

[sv/rpf_mix.sv]
`timescale 1ns / 1ps

module rpf_mix (
    input  logic [rpf_pkg::COLOR_W-1:0] i_source,
    input  logic [rpf_pkg::COLOR_W-1:0] i_blend,
    input  logic [rpf_pkg::HALF_W-1:0]  i_half,
    input  logic                        i_fade_en,
    output logic [rpf_pkg::COLOR_W-1:0] o_color
);
    import rpf_pkg::*;

    logic [HALF_W-1:0]  inv_half;
    logic [COLOR_W-1:0] mixed;

    // Weight of the blend color is the remainder of the span.
    assign inv_half = BLEND_SPAN - i_half;

    // Each 5-bit channel is a weighted average of source and blend color.
    always_comb begin
        logic [CHAN_W+HALF_W-1:0] src_term;
        logic [CHAN_W+HALF_W-1:0] tgt_term;
        logic [CHAN_W+HALF_W-1:0] sum;
        mixed = '0;
        for (int ch = 0; ch < 3; ch++) begin
            src_term = {{HALF_W{1'b0}}, i_source[ch*CHAN_W +: CHAN_W]} *
                       {{CHAN_W{1'b0}}, i_half};
            tgt_term = {{HALF_W{1'b0}}, i_blend[ch*CHAN_W +: CHAN_W]} *
                       {{CHAN_W{1'b0}}, inv_half};
            sum      = src_term + tgt_term;
            mixed[ch*CHAN_W +: CHAN_W] = sum[CHAN_W +: CHAN_W];
        end
    end

    // Entries outside the faded rows, or at unity level, pass unchanged.
    assign o_color = i_fade_en ? mixed : i_source;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import rpf_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int unsigned QUIET_LIMIT  = 2000;
    // Cycles allowed for the two-stage pipeline to settle.
    localparam int unsigned SETTLE_TICKS = 4;
    localparam int unsigned DRAIN_TICKS  = 8;
    localparam int unsigned RAND_PHASES  = 12;

    // Clock, reset and block ports.
    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic [LEVEL_W-1:0] bright_a = UNITY_LEVEL;
    logic [LEVEL_W-1:0] bright_b = UNITY_LEVEL;
    logic [MASK_W-1:0]  row_mask = RESET_MASK;
    logic [COLOR_W-1:0] blend_rgb = RESET_BLEND;

    // Entries waiting to be sent and faded colors waiting to arrive.
    t_in_item  entry_queue[$];
    t_out_item faded_queue[$];
    t_out_item faded_want;

    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    logic        bad_item;

    rgb555_palette_row_fade i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Factor writes keep the low seven bits and saturate at unity.
    function automatic logic [LEVEL_W-1:0] clamp_brightness(logic [CFG_DATA_W-1:0] raw);
        logic [LEVEL_W-1:0] f;
        f = raw[LEVEL_W-1:0];
        return (f > UNITY_LEVEL) ? UNITY_LEVEL : f;
    endfunction

    // Expected result for one palette entry under the current settings.
    function automatic t_out_item fade_entry(t_in_item entry);
        t_out_item   res;
        int unsigned prod;
        int unsigned level;
        int unsigned half;
        int unsigned mix;
        logic [3:0]  row;
        prod  = int'(bright_a) * int'(bright_b);
        level = prod >> 6;
        half  = prod >> 7;
        row   = entry.entry_index[7:4];
        res.entry_out       = entry.entry_index;
        res.faded_color     = entry.source_color;
        res.effective_level = LEVEL_W'(level);
        if (level != UNITY_LEVEL && row_mask[row]) begin
            for (int ch = 0; ch < 3; ch++) begin
                mix = int'(entry.source_color[ch*CHAN_W +: CHAN_W]) * half
                    + int'(blend_rgb[ch*CHAN_W +: CHAN_W]) * (32 - half);
                res.faded_color[ch*CHAN_W +: CHAN_W] = CHAN_W'(mix >> 5);
            end
        end
        return res;
    endfunction

    // Entry sender: holds the item until it is taken, may idle between items.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                faded_queue.push_back(fade_entry(in_item));
            end
            if (!in_valid || in_ready) begin
                if (entry_queue.size() != 0 && $urandom_range(1, 100) > src_idle_pct) begin
                    in_valid <= 1'b1;
                    in_item  <= entry_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result checker: compares each faded entry with the oldest expectation.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (faded_queue.size() == 0) begin
                    $error("unexpected item: entry_out %0d", out_item.entry_out);
                    fail_count++;
                end else begin
                    faded_want = faded_queue.pop_front();
                    bad_item = 1'b0;
                    if (out_item.entry_out !== faded_want.entry_out) begin
                        $error("entry_out: expected %0d, got %0d",
                               faded_want.entry_out, out_item.entry_out);
                        bad_item = 1'b1;
                    end
                    if (out_item.faded_color !== faded_want.faded_color) begin
                        $error("faded_color: expected 0x%04h, got 0x%04h",
                               faded_want.faded_color, out_item.faded_color);
                        bad_item = 1'b1;
                    end
                    if (out_item.effective_level !== faded_want.effective_level) begin
                        $error("effective_level: expected %0d, got %0d",
                               faded_want.effective_level, out_item.effective_level);
                        bad_item = 1'b1;
                    end
                    if (bad_item) begin
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(1, 100) > sink_idle_pct);
        end
    end

    // Watchdog: ends a run in which no item moves for too long.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // One register write, held for a single cycle; the shadow copy follows it.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_BRIGHT_FIRST:  bright_a = clamp_brightness(data);
            CFG_BRIGHT_SECOND: bright_b = clamp_brightness(data);
            CFG_FADE_MASK:     row_mask = data[MASK_W-1:0];
            CFG_BLEND_COLOR:   blend_rgb = data[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    // Sampled on the falling edge, after every update of the rising edge has settled.
    task automatic wait_drained();
        @(negedge i_clk);
        while (entry_queue.size() != 0 || in_valid || faded_queue.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Reprogram all four registers once the pipeline is empty.
    task automatic set_fade(logic [CFG_DATA_W-1:0] fa, logic [CFG_DATA_W-1:0] fb,
                            logic [CFG_DATA_W-1:0] mask, logic [CFG_DATA_W-1:0] blend);
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        write_reg(CFG_BRIGHT_FIRST, fa);
        write_reg(CFG_BRIGHT_SECOND, fb);
        write_reg(CFG_FADE_MASK, mask);
        write_reg(CFG_BLEND_COLOR, blend);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_entry(logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] color);
        t_in_item entry;
        entry.entry_index  = idx;
        entry.source_color = color;
        entry_queue.push_back(entry);
    endtask

    // Factor values: zero, unity, out-of-range raw writes and anything between.
    function automatic logic [CFG_DATA_W-1:0] pick_factor();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_DATA_W'(UNITY_LEVEL);
            2:       return CFG_DATA_W'($urandom_range(65, 16'hFFFF));
            default: return CFG_DATA_W'($urandom_range(0, 64));
        endcase
    endfunction

    initial begin
        int unsigned n_items;
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] blend;

        src_idle_pct  = 23;
        sink_idle_pct = 66;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        // Reset settings: unity level and an empty mask leave every entry alone.
        send_entry(8'h00, 15'h0000);
        send_entry(8'hFF, 15'h7FFF);
        send_entry(8'h5A, 15'h2AD5);

        // Unity level with every row selected still passes entries through.
        set_fade(16'd64, 16'd64, 16'hFFFF, 16'h1234);
        send_entry(8'h01, 15'h7FFF);
        send_entry(8'hF0, 15'h5555);
        send_entry(8'h80, 15'h0000);

        // Level zero turns every selected entry into the blend color.
        set_fade(16'd0, 16'd64, 16'hFFFF, 16'h7FFF);
        send_entry(8'h00, 15'h0000);
        send_entry(8'h7F, 15'h1084);
        send_entry(8'hFF, 15'h7C1F);

        // Oversized factor saturates; black blend on the first and last rows.
        set_fade(16'h00C5, 16'd32, 16'h8001, 16'h0000);
        send_entry(8'h00, 15'h7FFF);
        send_entry(8'h0F, 15'h03E0);
        send_entry(8'h10, 15'h7FFF);
        send_entry(8'hEF, 15'h7FFF);
        send_entry(8'hFF, 15'h7C00);

        // Just below unity with alternate rows and a white blend.
        set_fade(16'd63, 16'hFFFF, 16'h5555, 16'hFFFF);
        send_entry(8'h00, 15'h0000);
        send_entry(8'h10, 15'h0000);
        send_entry(8'h2C, 15'h7FFF);

        // Factors whose product drops to level zero; high raw bits are dropped.
        set_fade(16'd1, 16'h0081, 16'hAAAA, 16'h4A52);
        send_entry(8'h10, 15'h7FFF);
        send_entry(8'h20, 15'h7FFF);
        send_entry(8'hF3, 15'h0421);

        // Random settings and entries, through the three pacing patterns.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       mask = '0;
                1:       mask = 16'hFFFF;
                default: mask = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            endcase
            case ($urandom_range(0, 4))
                0:       blend = '0;
                1:       blend = 16'h7FFF;
                2:       blend = 16'hFFFF;
                default: blend = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            endcase
            set_fade(pick_factor(), pick_factor(), mask, blend);
            if (phase == RAND_PHASES / 3) begin
                src_idle_pct  = 66;
                sink_idle_pct = 23;
            end else if (phase == 2 * RAND_PHASES / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            n_items = $urandom_range(25, 42);
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_entry($urandom_range(0, 1) ? 8'hFF : 8'h00,
                               $urandom_range(0, 1) ? 15'h7FFF : 15'h0000);
                end else begin
                    send_entry(INDEX_W'($urandom_range(0, 255)),
                               COLOR_W'($urandom_range(0, 32767)));
                end
            end
        end

        // Let the pipeline empty, then check that nothing else comes out.
        wait_drained();
        repeat (DRAIN_TICKS) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
